// ===== rtl/core/pgmd_pkg.sv =====
// package for the pcm gain and mono downmix block: types, codes and format helpers
package pgmd_pkg;

  localparam int SMP_W     = 40;   // signed width of decoded and gained sample values
  localparam int MAG_W     = 32;   // magnitude of a re-centred sample
  localparam int DVD_W     = 47;   // product magnitude and dividend width
  localparam int REM_W     = 10;   // divider remainder, covers channel counts
  localparam int GAIN_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_STEPS = GAIN_W;
  localparam int GAIN_DIV  = 1000;
  localparam int DEF_MAX_CHANNELS = 8;

  // ceil(2**53 / 1000); exact floor of p / 1000 for every product p below 2**47
  localparam int RCP_W  = 44;
  localparam int RCP_SH = 9;       // 53 minus the 44 bits already shifted out
  localparam logic [RCP_W-1:0] GAIN_RCP = 44'd9007199254741;

  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S8  = 3'd1,
    FMT_U16 = 3'd2,
    FMT_S16 = 3'd3,
    FMT_U24 = 3'd4,
    FMT_S24 = 3'd5,
    FMT_U32 = 3'd6,
    FMT_S32 = 3'd7
  } fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_FORMAT = 3'd0,
    CFG_CHANNEL_COUNT = 3'd1,
    CFG_GAIN_PERMILLE = 3'd2,
    CFG_GAIN_ENABLE   = 3'd3,
    CFG_MONO_ENABLE   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RCP,
    ST_DIV,
    ST_POST,
    ST_EMIT
  } state_e;

  // container bits to a signed value in the format's range
  function automatic logic signed [SMP_W-1:0] pgmd_decode(logic [31:0] w, fmt_e f);
    logic signed [SMP_W-1:0] r;
    case (f)
      FMT_U8:  r = {{(SMP_W-8){1'b0}}, w[7:0]};
      FMT_S8:  r = {{(SMP_W-8){w[7]}}, w[7:0]};
      FMT_U16: r = {{(SMP_W-16){1'b0}}, w[15:0]};
      FMT_S16: r = {{(SMP_W-16){w[15]}}, w[15:0]};
      FMT_U24: r = {{(SMP_W-24){1'b0}}, w[23:0]};
      FMT_S24: r = {{(SMP_W-24){w[23]}}, w[23:0]};
      FMT_U32: r = {{(SMP_W-32){1'b0}}, w[31:0]};
      FMT_S32: r = {{(SMP_W-32){w[31]}}, w[31:0]};
      default: r = '0;
    endcase
    return r;
  endfunction

  // re-centring offset of unsigned formats
  function automatic logic signed [SMP_W-1:0] pgmd_offset(fmt_e f);
    logic signed [SMP_W-1:0] r;
    case (f)
      FMT_U8:  r = 40'sd127;
      FMT_U16: r = 40'sd32767;
      FMT_U24: r = 40'sd8388608;
      FMT_U32: r = 40'sd2147483647;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [SMP_W-1:0] pgmd_clamp(logic signed [SMP_W-1:0] v, fmt_e f);
    logic signed [SMP_W-1:0] lo;
    logic signed [SMP_W-1:0] hi;
    logic signed [SMP_W-1:0] r;
    case (f)
      FMT_U8:  begin lo = '0;              hi = 40'sd255;        end
      FMT_S8:  begin lo = -40'sd128;       hi = 40'sd127;        end
      FMT_U16: begin lo = '0;              hi = 40'sd65535;      end
      FMT_S16: begin lo = -40'sd32768;     hi = 40'sd32767;      end
      FMT_U24: begin lo = '0;              hi = 40'sd16777215;   end
      FMT_S24: begin lo = -40'sd8388608;   hi = 40'sd8388607;    end
      FMT_U32: begin lo = '0;              hi = 40'sd4294967295; end
      FMT_S32: begin lo = -40'sd2147483648; hi = 40'sd2147483647; end
      default: begin lo = '0;              hi = '0;              end
    endcase
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pcm_gain_mono_downmix.sv =====
// pcm digital volume with mono downmix: sequencer around one shared add/subtract unit
// with gain off or unity a sample goes from the idle state through the post state to the
//   output register; with gain on it first takes 16 shift-add multiply steps and 44 shift-add
//   steps multiplying by the reciprocal of 1000; the last sample of a mono frame adds
//   (33 + clog2(MAX_CHANNELS)) restoring divide steps and an emit state
// flow: the input is held off while a sample is in the sequencer; a mono frame then
//   streams out one result per cycle while the receiver is ready
// reset: rst_ni asynchronous active low, configuration registers return to S16, 2 channels, unity gain
module pcm_gain_mono_downmix import pgmd_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // input sample stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [31:0]          s_axis_tdata_i,   // [31:0] sample_word
  // result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [31:0]          m_axis_tdata_o,   // [31:0] sample_result
  output logic                 m_axis_tlast_o    // frame_last
);

  localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W  = 33 + $clog2(MAX_CHANNELS);
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int ALU_W  = DVD_W + 1;
  localparam int RIDX_W = $clog2(RCP_W);

  // configuration registers
  fmt_e              fmt_q, fmt_d;
  logic [3:0]        chan_q, chan_d;
  logic [GAIN_W-1:0] gain_q, gain_d;
  logic              gain_en_q, gain_en_d;
  logic              mono_q, mono_d;

  // sequencer and datapath registers
  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [DVD_W-1:0]         acc_q, acc_d;      // product, reciprocal-pass sum, then dividend and quotient
  logic [DVD_W-1:0]         mcand_q, mcand_d;
  logic [GAIN_W-1:0]        mplier_q, mplier_d;
  logic [REM_W-1:0]         rem_q, rem_d;
  logic [REM_W-1:0]         divisor_q, divisor_d;
  logic                     neg_q, neg_d;
  logic signed [SMP_W-1:0]  smp_q, smp_d;
  logic [CH_W-1:0]          pos_q, pos_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic [31:0]              out_data_q, out_data_d;
  logic                     out_last_q, out_last_d;
  logic [CH_W-1:0]          out_cnt_q, out_cnt_d;

  // shared add/subtract unit
  logic [ALU_W-1:0]         alu_a, alu_b, alu_res;
  logic                     alu_sub;

  logic [CH_W-1:0]          ch_act;
  logic                     out_free;
  logic                     gain_act;
  logic signed [SMP_W-1:0]  x_dec, x_ctr;
  logic [SMP_W-1:0]         x_mag;
  logic [REM_W:0]           rem_sh;
  logic                     div_ge;
  logic [DVD_W-1:0]         quot;
  logic [SMP_W-1:0]         q_low;
  logic signed [SMP_W-1:0]  q_sgn;
  logic [RIDX_W-1:0]        rcp_idx;
  logic                     rcp_bit;
  logic [DVD_W-1:0]         rcp_hi;
  logic [SMP_W-1:0]         g_low;
  logic signed [SMP_W-1:0]  g_sgn;
  logic signed [SUM_W-1:0]  sum_new;
  logic [SUM_W-1:0]         sum_abs;
  logic [CH_W-1:0]          pos_inc;

  // zero channels acts as one, counts above the maximum saturate
  always_comb begin
    if (chan_q == '0) begin
      ch_act = CH_W'(1);
    end else if (int'(chan_q) > MAX_CHANNELS) begin
      ch_act = CH_W'(MAX_CHANNELS);
    end else begin
      ch_act = CH_W'(chan_q);
    end
  end

  assign gain_act = gain_en_q && (gain_q != GAIN_W'(GAIN_DIV));
  assign out_free = !out_valid_q || (m_axis_tready_i && (out_cnt_q == CH_W'(1)));

  assign x_dec  = pgmd_decode(s_axis_tdata_i, fmt_q);
  assign x_ctr  = x_dec - pgmd_offset(fmt_q);
  assign x_mag  = x_ctr[SMP_W-1] ? SMP_W'(-x_ctr) : SMP_W'(x_ctr);

  // restoring divide step, quotient bits shift into the dividend register
  assign rem_sh = {rem_q, acc_q[DVD_W-1]};
  assign div_ge = !alu_res[ALU_W-1];
  assign quot   = {acc_q[DVD_W-2:0], div_ge};
  assign q_low  = quot[SMP_W-1:0];
  assign q_sgn  = neg_q ? -$signed(q_low) : $signed(q_low);

  // divide by 1000: product times the reciprocal, lsb first, keeping only the upper half
  assign rcp_idx = RIDX_W'(RCP_W) - RIDX_W'(cnt_q);
  assign rcp_bit = GAIN_RCP[rcp_idx];
  assign rcp_hi  = alu_res[ALU_W-1:1];
  assign g_low   = SMP_W'(rcp_hi[DVD_W-1:RCP_SH]);
  assign g_sgn   = neg_q ? -$signed(g_low) : $signed(g_low);

  assign sum_new = alu_res[SUM_W-1:0];
  assign sum_abs = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
  assign pos_inc = pos_q + 1'b1;

  // operand selection for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_MUL: begin
        alu_a = ALU_W'(acc_q);
        alu_b = mplier_q[0] ? ALU_W'(mcand_q) : '0;
      end
      ST_RCP: begin
        alu_a = ALU_W'(acc_q);
        alu_b = rcp_bit ? ALU_W'(mcand_q) : '0;
      end
      ST_DIV: begin
        alu_a   = ALU_W'(rem_sh);
        alu_b   = ALU_W'(divisor_q);
        alu_sub = 1'b1;
      end
      ST_POST: begin
        alu_a = ALU_W'(sum_q);
        alu_b = ALU_W'(smp_q);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // next state, datapath and output register
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    rem_d       = rem_q;
    divisor_d   = divisor_q;
    neg_d       = neg_q;
    smp_d       = smp_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    fmt_d       = fmt_q;
    chan_d      = chan_q;
    gain_d      = gain_q;
    gain_en_d   = gain_en_q;
    mono_d      = mono_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_cnt_d   = out_cnt_q;

    // drain: repeat the held result until its count runs out
    if (out_valid_q && m_axis_tready_i) begin
      if (out_cnt_q == CH_W'(1)) begin
        out_valid_d = 1'b0;
      end else begin
        out_cnt_d  = out_cnt_q - 1'b1;
        out_last_d = (out_cnt_q == CH_W'(2));
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (gain_act) begin
            neg_d    = x_ctr[SMP_W-1];
            mcand_d  = DVD_W'(x_mag[MAG_W-1:0]);
            acc_d    = '0;
            mplier_d = gain_q;
            cnt_d    = CNT_W'(MUL_STEPS);
            state_d  = ST_MUL;
          end else begin
            smp_d   = x_dec;
            state_d = ST_POST;
          end
        end
      end
      ST_MUL: begin
        acc_d    = alu_res[DVD_W-1:0];
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          // product becomes the multiplicand of the reciprocal pass
          mcand_d = alu_res[DVD_W-1:0];
          acc_d   = '0;
          cnt_d   = CNT_W'(RCP_W);
          state_d = ST_RCP;
        end
      end
      ST_RCP: begin
        acc_d = rcp_hi;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          smp_d   = pgmd_clamp(g_sgn + pgmd_offset(fmt_q), fmt_q);
          state_d = ST_POST;
        end
      end
      ST_DIV: begin
        acc_d = quot;
        rem_d = div_ge ? alu_res[REM_W-1:0] : rem_sh[REM_W-1:0];
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          smp_d   = pgmd_clamp(q_sgn, fmt_q);
          state_d = ST_EMIT;
        end
      end
      ST_POST: begin
        if (!mono_q || (ch_act < CH_W'(2))) begin
          // single-sample pass
          if (out_free) begin
            out_valid_d = 1'b1;
            out_data_d  = smp_q[31:0];
            out_last_d  = 1'b1;
            out_cnt_d   = CH_W'(1);
            pos_d       = '0;
            sum_d       = '0;
            state_d     = ST_IDLE;
          end
        end else if (pos_inc < ch_act) begin
          sum_d   = sum_new;
          pos_d   = pos_inc;
          state_d = ST_IDLE;
        end else begin
          // frame complete: divide the sum magnitude by the channel count
          neg_d     = sum_new[SUM_W-1];
          acc_d     = DVD_W'(sum_abs) << (DVD_W - SUM_W);
          rem_d     = '0;
          divisor_d = REM_W'(ch_act);
          cnt_d     = CNT_W'(SUM_W);
          pos_d     = '0;
          sum_d     = '0;
          state_d   = ST_DIV;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = smp_q[31:0];
          out_last_d  = (ch_act == CH_W'(1));
          out_cnt_d   = ch_act;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // frame-shaping writes drop a partial frame
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SAMPLE_FORMAT: begin
          fmt_d = fmt_e'(cfg_wdata_i[2:0]);
          pos_d = '0;
          sum_d = '0;
        end
        CFG_CHANNEL_COUNT: begin
          chan_d = cfg_wdata_i[3:0];
          pos_d  = '0;
          sum_d  = '0;
        end
        CFG_GAIN_PERMILLE: gain_d    = cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_ENABLE:   gain_en_d = cfg_wdata_i[0];
        CFG_MONO_ENABLE: begin
          mono_d = cfg_wdata_i[0];
          pos_d  = '0;
          sum_d  = '0;
        end
        default: begin
          gain_d = gain_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      sum_q       <= '0;
      fmt_q       <= FMT_S16;
      chan_q      <= 4'd2;
      gain_q      <= GAIN_W'(GAIN_DIV);
      gain_en_q   <= 1'b0;
      mono_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      fmt_q       <= fmt_d;
      chan_q      <= chan_d;
      gain_q      <= gain_d;
      gain_en_q   <= gain_en_d;
      mono_q      <= mono_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      out_cnt_q   <= out_cnt_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    rem_q      <= rem_d;
    divisor_q  <= divisor_d;
    neg_q      <= neg_d;
    smp_q      <= smp_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTH
  a_out_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_cnt_q != '0))
    else $error("held result with zero repeat count");

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (pos_q < ch_act))
    else $error("frame position beyond channel count");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < divisor_q))
    else $error("divider remainder not below divisor");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q != ST_IDLE))
    else $error("sequencer idle right after an input transfer");
`endif

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the pcm gain and mono downmix block
module tb;
  import pgmd_pkg::*;

  localparam int MAX_CH       = 8;
  localparam longint UNITY    = 1000;     // gain in thousandths that leaves samples alone
  localparam int IDLE_CYCLES  = 120;      // covers the gain pass plus the frame average
  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_LIMIT  = 50000;

  // one expected result, fields as they travel on the result stream
  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } pcm_out_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [31:0]          s_axis_tdata_i = '0;   // [31:0] sample_word
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [31:0]          m_axis_tdata_o;        // [31:0] sample_result
  logic                 m_axis_tlast_o;        // frame_last

  // register mirror and frame state of the downmix predictor
  fmt_e        m_fmt = FMT_S16;
  logic [3:0]  m_chans = 4'd2;
  logic [15:0] m_gain = 16'd1000;
  logic        m_gain_en = 1'b0;
  logic        m_mono_en = 1'b0;
  int          m_pos = 0;
  longint      m_sum = 0;

  pcm_out_t pcm_out_q[$];

  int fails = 0;
  int items_sent = 0;
  int results_seen = 0;
  int frames_averaged = 0;
  int avg_results = 0;
  int reg_writes = 0;

  // sender bursts and receiver stall pattern
  bit          tx_idle = 1'b0;
  int          burst_left = 0;
  bit          rx_stall = 1'b0;
  logic [15:0] rx_tick = '0;

  pcm_gain_mono_downmix #(
    .MAX_CHANNELS(MAX_CH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- format arithmetic

  function automatic int fmt_width(fmt_e f);
    case (f)
      FMT_U8, FMT_S8:   return 8;
      FMT_U16, FMT_S16: return 16;
      FMT_U24, FMT_S24: return 24;
      default:          return 32;
    endcase
  endfunction

  function automatic bit fmt_is_signed(fmt_e f);
    return f inside {FMT_S8, FMT_S16, FMT_S24, FMT_S32};
  endfunction

  function automatic longint range_lo(fmt_e f);
    if (!fmt_is_signed(f)) return 0;
    return -(longint'(1) << (fmt_width(f) - 1));
  endfunction

  function automatic longint range_hi(fmt_e f);
    if (!fmt_is_signed(f)) return (longint'(1) << fmt_width(f)) - 1;
    return (longint'(1) << (fmt_width(f) - 1)) - 1;
  endfunction

  // unsigned formats are scaled around this point; note U24 uses the half-range itself
  function automatic longint centre(fmt_e f);
    case (f)
      FMT_U8:  return 127;
      FMT_U16: return 32767;
      FMT_U24: return 8388608;
      FMT_U32: return 2147483647;
      default: return 0;
    endcase
  endfunction

  function automatic longint saturate(longint v, fmt_e f);
    if (v < range_lo(f)) return range_lo(f);
    if (v > range_hi(f)) return range_hi(f);
    return v;
  endfunction

  // container bits to a value; bits above the format width are ignored
  function automatic longint to_value(logic [31:0] word, fmt_e f);
    int     w;
    longint v;
    w = fmt_width(f);
    v = longint'(word) & ((longint'(1) << w) - 1);
    if (fmt_is_signed(f) && ((v >> (w - 1)) & 1) != 0) v = v - (longint'(1) << w);
    return v;
  endfunction

  function automatic longint scaled(longint x);
    longint t;
    if (!m_gain_en || longint'(m_gain) == UNITY) return x;
    t = (x - centre(m_fmt)) * longint'(m_gain);
    t = t / UNITY;                     // truncates toward zero
    return saturate(t + centre(m_fmt), m_fmt);
  endfunction

  // zero acts as one, anything above the build limit saturates
  function automatic int active_channels();
    int c;
    c = int'(m_chans);
    if (c < 1) c = 1;
    if (c > MAX_CH) c = MAX_CH;
    return c;
  endfunction

  // expected results of one accepted sample
  task automatic predict_pcm_out(input logic [31:0] word);
    int       ch;
    longint   s;
    longint   avg;
    pcm_out_t r;
    ch = active_channels();
    s  = scaled(to_value(word, m_fmt));
    if (!m_mono_en || ch < 2) begin
      m_pos = 0;
      m_sum = 0;
      r.word = s[31:0];
      r.last = 1'b1;
      pcm_out_q.push_back(r);
    end else begin
      m_sum = m_sum + s;
      m_pos++;
      if (m_pos == ch) begin
        avg = saturate(m_sum / longint'(ch), m_fmt);
        for (int k = 0; k < ch; k++) begin
          r.word = avg[31:0];
          r.last = (k == ch - 1);
          pcm_out_q.push_back(r);
        end
        m_pos = 0;
        m_sum = 0;
        frames_averaged++;
        avg_results += ch;
      end
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  // min or max encoding of a format, with junk in the unused container bits
  function automatic logic [31:0] extreme_word(fmt_e f, bit top);
    int          w;
    logic [31:0] mask;
    logic [31:0] val;
    w    = fmt_width(f);
    mask = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    if (fmt_is_signed(f)) val = top ? (mask >> 1) : ~(mask >> 1) & mask;
    else val = top ? mask : 32'd0;
    return ($urandom & ~mask) | (val & mask);
  endfunction

  function automatic logic [31:0] rand_word(fmt_e f);
    logic [31:0] near;
    case ($urandom_range(0, 9))
      0: return extreme_word(f, 1'b0);
      1: return extreme_word(f, 1'b1);
      2, 3: begin
        // small steps around the scaling centre
        near = 32'(centre(f)) + 32'($urandom_range(0, 64)) - 32'd32;
        return ($urandom_range(0, 1) != 0) ? (near | ($urandom << fmt_width(f))) : near;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd999;
      3:       return 16'd1000;
      4:       return 16'd1001;
      5:       return 16'hFFFF;
      6:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(500, 2000));
    endcase
  endfunction

  // one sample transfer; tvalid stays high on return so a burst can continue
  task automatic send_sample(input logic [31:0] word);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = 0;
      if (tx_idle) gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    predict_pcm_out(word);
  endtask

  // drop the stream, let every expected result come out and the block go idle
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (pcm_out_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only called with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_SAMPLE_FORMAT: m_fmt = fmt_e'(val[2:0]);
      CFG_CHANNEL_COUNT: m_chans = val[3:0];
      CFG_GAIN_PERMILLE: m_gain = val[15:0];
      CFG_GAIN_ENABLE:   m_gain_en = val[0];
      CFG_MONO_ENABLE:   m_mono_en = val[0];
      default: ;
    endcase
    // frame-shaping registers drop any partial frame
    if (idx inside {CFG_SAMPLE_FORMAT, CFG_CHANNEL_COUNT, CFG_MONO_ENABLE}) begin
      m_pos = 0;
      m_sum = 0;
    end
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- result check

  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1'b1;
    m_axis_tready_i <= !rx_stall || ((rx_tick % 16'd5 != 16'd2) && (rx_tick[3:0] < 4'd11));
  end

  always @(posedge clk_i) begin : check_pcm_out
    pcm_out_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (pcm_out_q.size() == 0) begin
        $error("unexpected result transfer: sample_result %h frame_last %b",
               m_axis_tdata_o, m_axis_tlast_o);
        fails++;
      end else begin
        exp_r = pcm_out_q.pop_front();
        if (m_axis_tdata_o !== exp_r.word) begin
          $error("sample_result: expected %h, actual %h", exp_r.word, m_axis_tdata_o);
          fails++;
        end
        if (m_axis_tlast_o !== exp_r.last) begin
          $error("frame_last: expected %b, actual %b", exp_r.last, m_axis_tlast_o);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // reset values: S16, gain off, mono off, so samples pass normalised
  task automatic test_reset_passthrough();
    send_sample(32'h0000_8000);
    send_sample(32'hFFFF_7FFF);
    send_sample(32'h1234_0000);
  endtask

  // full-scale gain drives every format into its low or high rail, then zero gain
  task automatic test_gain_saturation();
    settle();
    write_reg(CFG_GAIN_PERMILLE, 16'hFFFF);
    write_reg(CFG_GAIN_ENABLE, 16'd1);
    for (int f = 0; f < 8; f++) begin
      settle();
      write_reg(CFG_SAMPLE_FORMAT, CFG_W'(f));
      send_sample(extreme_word(fmt_e'(f), f[1]));
    end
    settle();
    write_reg(CFG_GAIN_PERMILLE, 16'd0);
    send_sample(32'h8000_0000);
  endtask

  // channel count zero acts as one, one channel passes singly, above the limit caps at 8
  task automatic test_channel_limits();
    settle();
    write_reg(CFG_GAIN_ENABLE, 16'd0);
    write_reg(CFG_SAMPLE_FORMAT, CFG_W'(FMT_S24));
    write_reg(CFG_MONO_ENABLE, 16'd1);
    write_reg(CFG_CHANNEL_COUNT, 16'd0);
    send_sample(32'hAB80_0000);
    settle();
    write_reg(CFG_CHANNEL_COUNT, 16'd1);
    send_sample(32'h007F_FFFF);
    settle();
    write_reg(CFG_CHANNEL_COUNT, 16'd15);
    for (int k = 0; k < MAX_CH; k++) send_sample(extreme_word(FMT_S24, 1'b1));
  endtask

  // writes to unused indexes keep a partial frame, a frame-shaping write drops it
  task automatic test_frame_clearing();
    settle();
    write_reg(CFG_SAMPLE_FORMAT, CFG_W'(FMT_S8));
    write_reg(CFG_CHANNEL_COUNT, 16'd2);
    send_sample(32'h0000_0080);
    settle();
    for (int i = int'(CFG_MONO_ENABLE) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), 16'hFFFF);
    end
    send_sample(32'hFFFF_FF81);
    send_sample(32'h0000_007F);
    settle();
    write_reg(CFG_MONO_ENABLE, 16'd1);
    send_sample(32'h0000_0003);
    send_sample(32'h0000_00FE);
  endtask

  // random settings per phase, mostly whole frames, some broken frames and mid-frame gain
  task automatic test_random_traffic();
    int random_items;
    int ch;
    int ch_raw;
    int split;
    int nframes;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      tx_idle  = ($urandom_range(0, 3) != 0);
      rx_stall = ($urandom_range(0, 3) != 0);
      ch_raw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      write_reg(CFG_SAMPLE_FORMAT, {13'($urandom), 3'($urandom_range(0, 7))});
      write_reg(CFG_CHANNEL_COUNT, {12'($urandom), 4'(ch_raw)});
      write_reg(CFG_GAIN_PERMILLE, pick_gain());
      write_reg(CFG_GAIN_ENABLE, {15'($urandom), 1'($urandom_range(0, 9) < 7)});
      write_reg(CFG_MONO_ENABLE, {15'($urandom), 1'($urandom_range(0, 1))});
      ch = active_channels();
      if (m_mono_en && ch > 1) begin
        nframes = $urandom_range(3, 40 / ch + 2);
        for (int fr = 0; fr < nframes; fr++) begin
          split = ($urandom_range(0, 11) == 0) ? $urandom_range(1, ch - 1) : 0;
          for (int k = 0; k < ch; k++) begin
            // gain is not frame-shaping, so the partial sum survives this write
            if (split != 0 && k == split) begin
              settle();
              write_reg(CFG_GAIN_PERMILLE, pick_gain());
            end
            send_sample(rand_word(m_fmt));
            random_items++;
          end
        end
        if ($urandom_range(0, 7) == 0) begin
          // broken frame, dropped by the next phase's writes
          for (int k = $urandom_range(1, ch - 1); k > 0; k--) begin
            send_sample(rand_word(m_fmt));
            random_items++;
          end
        end
      end else begin
        for (int k = $urandom_range(15, 40); k > 0; k--) begin
          send_sample(rand_word(m_fmt));
          random_items++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin : run_tests
    int waited;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_passthrough();
    tx_idle  = 1'b1;
    rx_stall = 1'b1;
    test_gain_saturation();
    tx_idle  = 1'b0;
    test_channel_limits();
    rx_stall = 1'b0;
    tx_idle  = 1'b1;
    test_frame_clearing();
    test_random_traffic();

    // wait out every expected result, then the block's own latency
    s_axis_tvalid_i <= 1'b0;
    waited = 0;
    while (pcm_out_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (IDLE_CYCLES) @(posedge clk_i);
    if (pcm_out_q.size() != 0) begin
      $error("%0d expected results never arrived", pcm_out_q.size());
      fails++;
    end

    $display("covered %0d samples over all eight formats and %0d register writes",
             items_sent, reg_writes);
    $display("checked %0d results, %0d of them from %0d averaged frames, %0d mismatches",
             results_seen, avg_results, frames_averaged, fails);
    if (fails == 0) begin
      $display("pcm_gain_mono_downmix regression: pass");
    end else begin
      $display("pcm_gain_mono_downmix regression: fail");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("pcm_gain_mono_downmix regression: fail");
    $finish;
  end

endmodule
